// ----- rtl/psc_pkg.sv -----
// ----------------------------------------------------------------------------
// psc_pkg: shared types and constants of the particle square collider
// Fixed point formats, register map, sequencer states and rounding helpers.
// ----------------------------------------------------------------------------
package psc_pkg;

  localparam int COORD_W    = 20;   // signed Q12.8 coordinate
  localparam int AXIS_W     = 16;   // signed Q2.14 axis component or gain
  localparam int AXIS_FRAC  = 14;
  localparam int CNT_W      = 32;

  // shared multiplier: A operand times one chunk of a wide B operand
  localparam int MUL_A_W    = 22;
  localparam int CHUNK_SH   = 25;
  localparam int MUL_B_W    = CHUNK_SH + 1;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int ACC_W      = 64;

  // internal value widths
  localparam int DIST_W     = 40;   // plane distances, normal velocity dot
  localparam int SIDE_W     = 41;   // side axis projections
  localparam int NUM_W      = 62;   // delta times far distance
  localparam int VPERP_W    = 28;
  localparam int POS_W      = 36;   // resolved positions before saturation
  localparam int PUSH_W     = 50;

  localparam int DIV_STEPS  = 22;   // quotient bits of the crossing ratio
  localparam int DCNT_W     = $clog2(DIV_STEPS + 1);
  localparam int COMP_W     = 2;

  // configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int REG_LSB    = 3;

  localparam int ORIGIN_W   = 3 * COORD_W;
  localparam int AXES_W     = 3 * AXIS_W;
  localparam int EXT_W      = 19;
  localparam int RESP_W     = 36;
  localparam int COLOR_W    = 32;

  localparam logic [AXES_W-1:0] AXIS_X_RST = 48'h0000_0000_4000;
  localparam logic [AXES_W-1:0] AXIS_Y_RST = 48'h0000_4000_0000;
  localparam logic [AXES_W-1:0] AXIS_Z_RST = 48'h4000_0000_0000;
  localparam logic [EXT_W-1:0]  EXT_RST    = 19'd256;

  // response register flag positions
  localparam int RESP_ENABLED  = 32;
  localparam int RESP_KILLER   = 33;
  localparam int RESP_NO_RES   = 34;
  localparam int RESP_USE_COL  = 35;

  typedef enum logic [2:0] {
    REG_ORIGIN, REG_AXIS_X, REG_AXIS_Y, REG_AXIS_Z,
    REG_HALF_W, REG_HALF_H, REG_RESPONSE, REG_HIT_COLOR
  } reg_idx_t;

  typedef enum logic {
    CMD_TICK, CMD_PARTICLE
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DA, ST_DB, ST_CHK, ST_NUM, ST_DIV, ST_SX, ST_SZ,
    ST_TEST, ST_VS, ST_VPERP, ST_SM, ST_BO, ST_DNY, ST_PUSH, ST_OUT
  } state_t;

  // round to nearest, ties toward plus infinity, then arithmetic shift
  function automatic logic signed [ACC_W-1:0] rnd_shr(
    input logic signed [ACC_W-1:0] x,
    input int unsigned             sh
  );
    logic signed [ACC_W-1:0] half;
    half = ACC_W'(64'sd1) <<< (sh - 1);
    return (x + half) >>> sh;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(
    input logic signed [POS_W-1:0] v
  );
    logic signed [POS_W-1:0] hi;
    logic signed [POS_W-1:0] lo;
    hi = POS_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
    lo = -POS_W'(64'sd1 <<< (COORD_W - 1));
    if (v > hi) return hi[COORD_W-1:0];
    if (v < lo) return lo[COORD_W-1:0];
    return v[COORD_W-1:0];
  endfunction

endpackage

// ----- rtl/particle_square_collider.sv -----
// ----------------------------------------------------------------------------
// particle_square_collider: Verlet particle versus finite square plane
// Crossing test, hit test against the square, resolve with friction and
// bounce, hit and idle tick counters.
// ----------------------------------------------------------------------------
// One item is worked on at a time; in_stall is high from acceptance until the
// result item is taken. A tick item and a particle while the collider is
// disabled go straight to the result; a particle whose segment does not cross
// the plane stops after the crossing check, and a crossing particle that
// misses the square or is not resolved stops after the hit test. Every
// product comes from the one shared multiplier, which forms it in two passes
// over 25-bit chunks of the wide operand, and each crossing coordinate comes
// from a radix-2 divider.
// Configuration is written through the APB-style port at byte address 8*i.
// ----------------------------------------------------------------------------
module particle_square_collider import psc_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [CFG_ADDR_W-1:0]        paddr,
  input  logic [CFG_DATA_W-1:0]        pwdata,
  output logic [CFG_DATA_W-1:0]        prdata,
  output logic                         pready,
  // input items
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         command,
  input  logic signed [COORD_W-1:0]    cur_x,
  input  logic signed [COORD_W-1:0]    cur_y,
  input  logic signed [COORD_W-1:0]    cur_z,
  input  logic signed [COORD_W-1:0]    prev_x,
  input  logic signed [COORD_W-1:0]    prev_y,
  input  logic signed [COORD_W-1:0]    prev_z,
  input  logic                         already_collided,
  // result items
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         hit,
  output logic signed [COORD_W-1:0]    new_cur_x,
  output logic signed [COORD_W-1:0]    new_cur_y,
  output logic signed [COORD_W-1:0]    new_cur_z,
  output logic signed [COORD_W-1:0]    new_prev_x,
  output logic signed [COORD_W-1:0]    new_prev_y,
  output logic signed [COORD_W-1:0]    new_prev_z,
  output logic                         set_base_frame,
  output logic                         killed,
  output logic                         recolor,
  output logic [CNT_W-1:0]             hits_so_far,
  output logic [CNT_W-1:0]             ticks_idle
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [ORIGIN_W-1:0] origin;
  logic [AXES_W-1:0]   axis_x;
  logic [AXES_W-1:0]   axis_y;
  logic [AXES_W-1:0]   axis_z;
  logic [EXT_W-1:0]    half_width;
  logic [EXT_W-1:0]    half_height;
  logic [RESP_W-1:0]   response;
  logic [COLOR_W-1:0]  hit_color;

  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[REG_LSB+2:REG_LSB]);

  always_ff @(posedge clk) begin
    if (rst) begin
      origin      <= '0;
      axis_x      <= AXIS_X_RST;
      axis_y      <= AXIS_Y_RST;
      axis_z      <= AXIS_Z_RST;
      half_width  <= EXT_RST;
      half_height <= EXT_RST;
      response    <= '0;
      hit_color   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ORIGIN:    origin      <= pwdata[ORIGIN_W-1:0];
        REG_AXIS_X:    axis_x      <= pwdata[AXES_W-1:0];
        REG_AXIS_Y:    axis_y      <= pwdata[AXES_W-1:0];
        REG_AXIS_Z:    axis_z      <= pwdata[AXES_W-1:0];
        REG_HALF_W:    half_width  <= pwdata[EXT_W-1:0];
        REG_HALF_H:    half_height <= pwdata[EXT_W-1:0];
        REG_RESPONSE:  response    <= pwdata[RESP_W-1:0];
        REG_HIT_COLOR: hit_color   <= pwdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ORIGIN:    prdata = CFG_DATA_W'(origin);
      REG_AXIS_X:    prdata = CFG_DATA_W'(axis_x);
      REG_AXIS_Y:    prdata = CFG_DATA_W'(axis_y);
      REG_AXIS_Z:    prdata = CFG_DATA_W'(axis_z);
      REG_HALF_W:    prdata = CFG_DATA_W'(half_width);
      REG_HALF_H:    prdata = CFG_DATA_W'(half_height);
      REG_RESPONSE:  prdata = CFG_DATA_W'(response);
      REG_HIT_COLOR: prdata = CFG_DATA_W'(hit_color);
      default:       prdata = '0;
    endcase
  end

  // unpack centre, axes and gains
  logic signed [COORD_W-1:0] org [3];
  logic signed [AXIS_W-1:0]  nx  [3];
  logic signed [AXIS_W-1:0]  ny  [3];
  logic signed [AXIS_W-1:0]  nz  [3];
  logic signed [AXIS_W-1:0]  smooth;
  logic signed [AXIS_W-1:0]  bounce;
  logic                      en_c, kill_c, nores_c, usec_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      org[i] = origin[COORD_W*i +: COORD_W];
      nx[i]  = axis_x[AXIS_W*i +: AXIS_W];
      ny[i]  = axis_y[AXIS_W*i +: AXIS_W];
      nz[i]  = axis_z[AXIS_W*i +: AXIS_W];
    end
  end

  assign smooth  = response[AXIS_W-1:0];
  assign bounce  = response[2*AXIS_W-1:AXIS_W];
  assign en_c    = response[RESP_ENABLED];
  assign kill_c  = response[RESP_KILLER];
  assign nores_c = response[RESP_NO_RES];
  assign usec_c  = response[RESP_USE_COL];

  // --------------------------------------------------------------------------
  // Sequencer and working registers
  // --------------------------------------------------------------------------
  state_t state, state_next;

  logic signed [COORD_W-1:0] cur  [3];
  logic signed [COORD_W-1:0] prv  [3];
  logic signed [COORD_W-1:0] ip   [3];
  logic signed [NUM_W-1:0]   num  [3];
  logic signed [VPERP_W-1:0] vperp[3];
  logic signed [POS_W-1:0]   nc_w [3];
  logic signed [POS_W-1:0]   np_w [3];
  logic                      coll_r;

  logic signed [DIST_W-1:0]  da, db, s_dot;
  logic [DIST_W-1:0]         dbm;
  logic [DIST_W:0]           sum;
  logic signed [SIDE_W-1:0]  lx, lz;
  logic signed [PUSH_W-1:0]  qv;

  logic [COMP_W-1:0]         comp;   // component under work
  logic [1:0]                sub;    // {chunk, phase} of the current term
  logic [DCNT_W-1:0]         dcnt;

  logic signed [ACC_W-1:0]   acc;
  logic signed [PROD_W-1:0]  prod;

  logic [ACC_W-1:0]          rem, dsh;
  logic [DIV_STEPS-2:0]      quo;

  logic                      hit_r, sbf_r, kil_r, rec_r;
  logic [CNT_W-1:0]          hit_total, ticks_since_hit;

  logic in_acc, out_acc;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // --------------------------------------------------------------------------
  // Decisions that steer the sequencer
  // --------------------------------------------------------------------------
  logic crossing, hit_c, term_end, comp_last, div_last;
  logic [SIDE_W-1:0] lx_abs, lz_abs;

  assign crossing  = da[DIST_W-1] != db[DIST_W-1];
  assign lx_abs    = lx[SIDE_W-1] ? SIDE_W'(-lx) : SIDE_W'(lx);
  assign lz_abs    = lz[SIDE_W-1] ? SIDE_W'(-lz) : SIDE_W'(lz);
  assign hit_c     = (lx_abs < (SIDE_W'(half_width)  << AXIS_FRAC)) &&
                     (lz_abs < (SIDE_W'(half_height) << AXIS_FRAC));
  assign term_end  = sub == 2'd3;
  assign comp_last = comp == COMP_W'(2);
  assign div_last  = dcnt == DCNT_W'(DIV_STEPS);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (command == CMD_TICK || !en_c) state_next = ST_OUT;
          else                              state_next = ST_DA;
        end
      end
      ST_DA:    if (term_end && comp_last) state_next = ST_DB;
      ST_DB:    if (term_end && comp_last) state_next = ST_CHK;
      ST_CHK:   state_next = crossing ? ST_NUM : ST_OUT;
      ST_NUM:   if (term_end && comp_last) state_next = ST_DIV;
      ST_DIV:   if (div_last && comp_last) state_next = ST_SX;
      ST_SX:    if (term_end && comp_last) state_next = ST_SZ;
      ST_SZ:    if (term_end && comp_last) state_next = ST_TEST;
      ST_TEST:  state_next = (hit_c && !kill_c && !nores_c) ? ST_VS : ST_OUT;
      ST_VS:    if (term_end && comp_last) state_next = ST_VPERP;
      ST_VPERP: if (term_end && comp_last) state_next = ST_SM;
      ST_SM:    if (term_end && comp_last) state_next = ST_BO;
      ST_BO:    if (term_end && comp_last) state_next = ST_DNY;
      ST_DNY:   if (term_end && comp_last) state_next = ST_PUSH;
      ST_PUSH:  if (term_end && comp_last) state_next = ST_OUT;
      ST_OUT:   if (out_acc) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Per-state outputs: handshake and multiplier operands
  // --------------------------------------------------------------------------
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [ACC_W-1:0]   mul_b;
  logic signed [ACC_W-1:0]   delta_c, vpar_c;

  assign delta_c = ACC_W'(cur[comp]) - ACC_W'(prv[comp]);
  assign vpar_c  = delta_c - ACC_W'(vperp[comp]);

  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    mul_a     = MUL_A_W'(ny[comp]);
    mul_b     = '0;
    unique case (state)
      ST_IDLE:  in_stall = 1'b0;
      ST_DA:    mul_b = ACC_W'(cur[comp]) - ACC_W'(org[comp]);
      ST_DB:    mul_b = ACC_W'(prv[comp]) - ACC_W'(org[comp]);
      ST_NUM: begin
        mul_a = MUL_A_W'(delta_c);
        mul_b = ACC_W'(dbm);
      end
      ST_SX: begin
        mul_a = MUL_A_W'(nx[comp]);
        mul_b = ACC_W'(ip[comp]) - ACC_W'(org[comp]);
      end
      ST_SZ: begin
        mul_a = MUL_A_W'(nz[comp]);
        mul_b = ACC_W'(ip[comp]) - ACC_W'(org[comp]);
      end
      ST_VS:    mul_b = delta_c;
      ST_VPERP: mul_b = ACC_W'(s_dot);
      ST_SM: begin
        mul_a = MUL_A_W'(smooth);
        mul_b = vpar_c;
      end
      ST_BO: begin
        mul_a = MUL_A_W'(bounce);
        mul_b = ACC_W'(vperp[comp]);
      end
      ST_DNY:   mul_b = ACC_W'(ip[comp]) - ACC_W'(np_w[comp]);
      ST_PUSH:  mul_b = ACC_W'(qv);
      ST_OUT:   out_valid = 1'b1;
      default: ;
    endcase
  end

  // split the wide operand: low chunk as unsigned, high chunk signed
  logic signed [MUL_B_W-1:0] b_chunk;
  logic signed [ACC_W-1:0]   prod_ext, prod_sh, sum_n;

  assign b_chunk  = sub[1] ? mul_b[CHUNK_SH+MUL_B_W-1:CHUNK_SH]
                           : {1'b0, mul_b[CHUNK_SH-1:0]};
  assign prod_ext = ACC_W'(prod);
  assign prod_sh  = sub[1] ? (prod_ext <<< CHUNK_SH) : prod_ext;
  assign sum_n    = acc + prod_sh;

  // rescaled results of one finished term
  logic signed [ACC_W-1:0] r14, r28;
  assign r14 = rnd_shr(sum_n, AXIS_FRAC);
  assign r28 = rnd_shr(sum_n, 2 * AXIS_FRAC);

  // divider step: trial subtract of the shifted divisor
  logic                  div_ge;
  logic [DIV_STEPS-1:0]  q_full;
  logic [ACC_W-1:0]      num_abs;
  logic signed [COORD_W+2:0] ip_calc;

  assign div_ge  = rem >= dsh;
  assign q_full  = {quo, div_ge};
  assign num_abs = num[comp][NUM_W-1] ? ACC_W'(-num[comp]) : ACC_W'(num[comp]);
  assign ip_calc = num[comp][NUM_W-1]
                 ? (COORD_W+3)'(prv[comp]) - (COORD_W+3)'(q_full)
                 : (COORD_W+3)'(prv[comp]) + (COORD_W+3)'(q_full);

  logic mul_state, dot_state;
  always_comb begin
    case (state)
      ST_DA, ST_DB, ST_SX, ST_SZ, ST_VS, ST_DNY: dot_state = 1'b1;
      default:                                   dot_state = 1'b0;
    endcase
    case (state)
      ST_NUM, ST_VPERP, ST_SM, ST_BO, ST_PUSH:   mul_state = 1'b1;
      default:                                   mul_state = dot_state;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      hit_total       <= '0;
      ticks_since_hit <= '0;
      comp            <= '0;
      sub             <= '0;
      dcnt            <= '0;
    end else begin
      state <= state_next;

      // capture an item and preset pass-through positions
      if (in_acc) begin
        cur[0] <= cur_x;  cur[1] <= cur_y;  cur[2] <= cur_z;
        prv[0] <= prev_x; prv[1] <= prev_y; prv[2] <= prev_z;
        coll_r <= already_collided;
        hit_r  <= 1'b0;
        sbf_r  <= 1'b0;
        kil_r  <= 1'b0;
        rec_r  <= 1'b0;
        acc    <= '0;
        comp   <= '0;
        sub    <= '0;
        dcnt   <= '0;
        if (command == CMD_TICK) begin
          if (ticks_since_hit != '1) ticks_since_hit <= ticks_since_hit + 1'b1;
          for (int i = 0; i < 3; i++) begin
            nc_w[i] <= '0;
            np_w[i] <= '0;
          end
        end else begin
          nc_w[0] <= POS_W'(cur_x);  nc_w[1] <= POS_W'(cur_y);
          nc_w[2] <= POS_W'(cur_z);
          np_w[0] <= POS_W'(prev_x); np_w[1] <= POS_W'(prev_y);
          np_w[2] <= POS_W'(prev_z);
        end
      end

      // shared multiplier: phase 0 multiplies, phase 1 accumulates
      if (mul_state) begin
        sub <= sub + 2'd1;
        if (!sub[0]) begin
          prod <= mul_a * b_chunk;
        end else if (!sub[1]) begin
          acc <= sum_n;
        end else begin
          comp <= comp_last ? '0 : comp + 1'b1;
          // keep summing across a dot product, restart after its last term
          acc  <= (dot_state && !comp_last) ? sum_n : '0;
          unique case (state)
            ST_NUM:   num[comp]   <= sum_n[NUM_W-1:0];
            ST_VPERP: vperp[comp] <= r28[VPERP_W-1:0];
            ST_SM:    np_w[comp]  <= POS_W'(ip[comp]) - r14[POS_W-1:0];
            ST_BO:    np_w[comp]  <= np_w[comp] + r14[POS_W-1:0];
            ST_PUSH: begin
              nc_w[comp] <= POS_W'(ip[comp]) + r28[POS_W-1:0];
              np_w[comp] <= np_w[comp] + r28[POS_W-1:0];
            end
            default: ;
          endcase
          if (comp_last) begin
            unique case (state)
              ST_DA:  da    <= sum_n[DIST_W-1:0];
              ST_DB:  db    <= sum_n[DIST_W-1:0];
              ST_SX:  lx    <= sum_n[SIDE_W-1:0];
              ST_SZ:  lz    <= sum_n[SIDE_W-1:0];
              ST_VS:  s_dot <= sum_n[DIST_W-1:0];
              ST_DNY: qv    <= PUSH_W'(sum_n + (ACC_W'(64'sd1) <<< AXIS_FRAC));
              default: ;
            endcase
          end
        end
      end

      // magnitudes of both distances and their sum
      if (state == ST_CHK) begin
        dbm <= db[DIST_W-1] ? DIST_W'(-db) : DIST_W'(db);
        sum <= (DIST_W+1)'(da[DIST_W-1] ? DIST_W'(-da) : DIST_W'(da)) +
               (DIST_W+1)'(db[DIST_W-1] ? DIST_W'(-db) : DIST_W'(db));
      end

      // crossing point, one component at a time, rounded quotient
      if (state == ST_DIV) begin
        if (dcnt == '0) begin
          rem  <= (num_abs << 1) + ACC_W'(sum);
          dsh  <= ACC_W'(sum) << DIV_STEPS;
          quo  <= '0;
          dcnt <= dcnt + 1'b1;
        end else begin
          if (div_ge) rem <= rem - dsh;
          dsh <= dsh >> 1;
          quo <= q_full[DIV_STEPS-2:0];
          if (div_last) begin
            ip[comp] <= ip_calc[COORD_W-1:0];
            dcnt     <= '0;
            comp     <= comp_last ? '0 : comp + 1'b1;
          end else begin
            dcnt <= dcnt + 1'b1;
          end
        end
      end

      // hit inside the square: count it and pick the reaction
      if (state == ST_TEST && hit_c) begin
        hit_r           <= 1'b1;
        ticks_since_hit <= '0;
        if (hit_total != '1) hit_total <= hit_total + 1'b1;
        sbf_r <= !coll_r;
        kil_r <= kill_c;
        rec_r <= !kill_c && usec_c;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result item
  // --------------------------------------------------------------------------
  assign hit            = hit_r;
  assign new_cur_x      = sat_coord(nc_w[0]);
  assign new_cur_y      = sat_coord(nc_w[1]);
  assign new_cur_z      = sat_coord(nc_w[2]);
  assign new_prev_x     = sat_coord(np_w[0]);
  assign new_prev_y     = sat_coord(np_w[1]);
  assign new_prev_z     = sat_coord(np_w[2]);
  assign set_base_frame = sbf_r;
  assign killed         = kil_r;
  assign recolor        = rec_r;
  assign hits_so_far    = hit_total;
  assign ticks_idle     = ticks_since_hit;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid)
    else $error("result shown while idle");

  a_hit_clears_ticks: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> ticks_idle == '0)
    else $error("hit did not clear idle ticks");

  a_flags_need_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && (killed || recolor || set_base_frame) |-> hit && !(killed && recolor))
    else $error("reaction flags without a hit");

  a_hits_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> hit_total >= $past(hit_total))
    else $error("hit counter decreased");

endmodule

// ----- bench/psc_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// psc_checker: result predictor and scoreboard for the square collider
// Watches both item channels, predicts each result from its own copy of the
// registers and counters, and compares every result field by field.
// ----------------------------------------------------------------------------
module psc_checker import psc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  reg_idx_t                  cfg_idx,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic                      command,
  input  logic signed [COORD_W-1:0] cur_x,
  input  logic signed [COORD_W-1:0] cur_y,
  input  logic signed [COORD_W-1:0] cur_z,
  input  logic signed [COORD_W-1:0] prev_x,
  input  logic signed [COORD_W-1:0] prev_y,
  input  logic signed [COORD_W-1:0] prev_z,
  input  logic                      already_collided,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic                      hit,
  input  logic signed [COORD_W-1:0] new_cur_x,
  input  logic signed [COORD_W-1:0] new_cur_y,
  input  logic signed [COORD_W-1:0] new_cur_z,
  input  logic signed [COORD_W-1:0] new_prev_x,
  input  logic signed [COORD_W-1:0] new_prev_y,
  input  logic signed [COORD_W-1:0] new_prev_z,
  input  logic                      set_base_frame,
  input  logic                      killed,
  input  logic                      recolor,
  input  logic [CNT_W-1:0]          hits_so_far,
  input  logic [CNT_W-1:0]          ticks_idle,
  output int                        fail_count,
  output int                        pending,
  output int                        hit_seen,
  output int                        result_seen
);

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] cx, cy, cz, px, py, pz;
    logic                      sbf, kil, rec;
    logic [CNT_W-1:0]          hits, ticks;
  } collide_res_t;

  collide_res_t outcome_q[$];

  logic [ORIGIN_W-1:0] m_origin;
  logic [AXES_W-1:0]   m_ax, m_ay, m_az;
  logic [EXT_W-1:0]    m_hw, m_hh;
  logic [RESP_W-1:0]   m_resp;
  logic [CNT_W-1:0]    m_hits, m_ticks;

  // round to nearest, ties toward plus infinity
  function automatic longint rnd_up(longint x, int sh);
    return (x + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint sat20(longint v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return v;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  task automatic predict_collision(output collide_res_t r);
    longint c[3], p[3], o[3], nx[3], ny[3], nz[3], rl[3], ip[3], nc[3], np[3];
    longint da, db, sum, num, q, lx, lz, s, sm, bo, vp, vpar, t, dq;
    c = '{cur_x, cur_y, cur_z};
    p = '{prev_x, prev_y, prev_z};
    r = '0;
    for (int i = 0; i < 3; i++) begin
      o[i]  = longint'($signed(m_origin[COORD_W*i +: COORD_W]));
      nx[i] = longint'($signed(m_ax[AXIS_W*i +: AXIS_W]));
      ny[i] = longint'($signed(m_ay[AXIS_W*i +: AXIS_W]));
      nz[i] = longint'($signed(m_az[AXIS_W*i +: AXIS_W]));
      nc[i] = c[i];
      np[i] = p[i];
    end
    if (cmd_t'(command) == CMD_TICK) begin
      if (m_ticks != '1) m_ticks++;
      for (int i = 0; i < 3; i++) begin
        nc[i] = 0;
        np[i] = 0;
      end
    end else if (m_resp[RESP_ENABLED]) begin
      da = 0;
      db = 0;
      for (int i = 0; i < 3; i++) begin
        da += ny[i] * (c[i] - o[i]);
        db += ny[i] * (p[i] - o[i]);
      end
      if ((da < 0) != (db < 0)) begin
        da = mag(da);
        db = mag(db);
        sum = da + db;
        // ratio divide: rounded to nearest, ties away from zero
        for (int i = 0; i < 3; i++) begin
          num = (c[i] - p[i]) * db;
          q = (2 * mag(num) + sum) / (2 * sum);
          ip[i] = p[i] + (num < 0 ? -q : q);
          rl[i] = ip[i] - o[i];
        end
        lx = mag(nx[0]*rl[0] + nx[1]*rl[1] + nx[2]*rl[2]);
        lz = mag(nz[0]*rl[0] + nz[1]*rl[1] + nz[2]*rl[2]);
        if (lx < (longint'(m_hw) <<< AXIS_FRAC) && lz < (longint'(m_hh) <<< AXIS_FRAC)) begin
          r.hit = 1'b1;
          m_ticks = '0;
          if (m_hits != '1) m_hits++;
          r.sbf = !already_collided;
          if (m_resp[RESP_KILLER]) begin
            r.kil = 1'b1;
          end else begin
            if (!m_resp[RESP_NO_RES]) begin
              sm = longint'($signed(m_resp[15:0]));
              bo = longint'($signed(m_resp[31:16]));
              s = 0;
              for (int i = 0; i < 3; i++) s += ny[i] * (c[i] - p[i]);
              dq = 0;
              for (int i = 0; i < 3; i++) begin
                vp = rnd_up(ny[i] * s, 2 * AXIS_FRAC);
                vpar = (c[i] - p[i]) - vp;
                nc[i] = ip[i];
                np[i] = ip[i] - rnd_up(vpar * sm, AXIS_FRAC) + rnd_up(vp * bo, AXIS_FRAC);
                dq += (nc[i] - np[i]) * ny[i];
              end
              dq += longint'(1) <<< AXIS_FRAC;
              for (int i = 0; i < 3; i++) begin
                t = rnd_up(ny[i] * dq, 2 * AXIS_FRAC);
                nc[i] += t;
                np[i] += t;
              end
            end
            r.rec = m_resp[RESP_USE_COL];
          end
        end
      end
    end
    r.cx = COORD_W'(sat20(nc[0])); r.cy = COORD_W'(sat20(nc[1]));
    r.cz = COORD_W'(sat20(nc[2]));
    r.px = COORD_W'(sat20(np[0])); r.py = COORD_W'(sat20(np[1]));
    r.pz = COORD_W'(sat20(np[2]));
    r.hits = m_hits;
    r.ticks = m_ticks;
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    collide_res_t e;
    if (rst) begin
      m_origin <= '0;
      m_ax <= AXIS_X_RST; m_ay <= AXIS_Y_RST; m_az <= AXIS_Z_RST;
      m_hw <= EXT_RST; m_hh <= EXT_RST;
      m_resp <= '0;
      m_hits = '0; m_ticks = '0;
      fail_count = 0; pending = 0; hit_seen = 0; result_seen = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_ORIGIN: m_origin <= cfg_data[ORIGIN_W-1:0];
          REG_AXIS_X: m_ax <= cfg_data[AXES_W-1:0];
          REG_AXIS_Y: m_ay <= cfg_data[AXES_W-1:0];
          REG_AXIS_Z: m_az <= cfg_data[AXES_W-1:0];
          REG_HALF_W: m_hw <= cfg_data[EXT_W-1:0];
          REG_HALF_H: m_hh <= cfg_data[EXT_W-1:0];
          REG_RESPONSE: m_resp <= cfg_data[RESP_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_collision(e);
        outcome_q.push_back(e);
      end
      if (out_valid && !out_stall) begin
        result_seen++;
        if (hit) hit_seen++;
        if (outcome_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          e = outcome_q.pop_front();
          if (hit != e.hit) report_mismatch("hit", hit, e.hit);
          if (new_cur_x != e.cx) report_mismatch("new_cur_x", new_cur_x, e.cx);
          if (new_cur_y != e.cy) report_mismatch("new_cur_y", new_cur_y, e.cy);
          if (new_cur_z != e.cz) report_mismatch("new_cur_z", new_cur_z, e.cz);
          if (new_prev_x != e.px) report_mismatch("new_prev_x", new_prev_x, e.px);
          if (new_prev_y != e.py) report_mismatch("new_prev_y", new_prev_y, e.py);
          if (new_prev_z != e.pz) report_mismatch("new_prev_z", new_prev_z, e.pz);
          if (set_base_frame != e.sbf) report_mismatch("set_base_frame", set_base_frame, e.sbf);
          if (killed != e.kil) report_mismatch("killed", killed, e.kil);
          if (recolor != e.rec) report_mismatch("recolor", recolor, e.rec);
          if (hits_so_far != e.hits) report_mismatch("hits_so_far", hits_so_far, e.hits);
          if (ticks_idle != e.ticks) report_mismatch("ticks_idle", ticks_idle, e.ticks);
        end
      end
      pending = outcome_q.size();
    end
  end

endmodule

// ----- bench/particle_square_collider_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// particle_square_collider_tb: random and directed test of the collider
// Drives particle and tick items in bursts over several register settings,
// stalls the result side, and takes the verdict from the checker.
// ----------------------------------------------------------------------------
module particle_square_collider_tb;
  import psc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 1750;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 0, in_stall;
  logic command = 0;
  logic signed [COORD_W-1:0] cur_x = 0, cur_y = 0, cur_z = 0;
  logic signed [COORD_W-1:0] prev_x = 0, prev_y = 0, prev_z = 0;
  logic already_collided = 0;
  logic out_valid, out_stall = 0;
  logic hit, set_base_frame, killed, recolor;
  logic signed [COORD_W-1:0] new_cur_x, new_cur_y, new_cur_z;
  logic signed [COORD_W-1:0] new_prev_x, new_prev_y, new_prev_z;
  logic [CNT_W-1:0] hits_so_far, ticks_idle;

  // checker snoops register writes at the access edge
  logic cfg_we;
  reg_idx_t cfg_idx;
  int fail_count, pending, hit_seen, result_seen;
  int idle_cycles = 0;
  int phase_count = 0;

  assign cfg_we = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[REG_LSB +: 3]);

  always #10 clk = ~clk;

  particle_square_collider i_dut (.*);

  psc_checker i_checker (.cfg_data(pwdata), .*);

  // watchdog: count cycles in which no item moves on either channel and no register is written
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d results outstanding", pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver stalls in runs of its own; some phases never stall
  always @(posedge clk) begin
    int mode;
    mode = phase_count % 4;
    if (rst || mode == 0) out_stall <= 0;
    else out_stall <= ($urandom_range(0, 9) < 3 * mode);
  end

  task automatic write_reg(reg_idx_t idx, logic [63:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= CFG_ADDR_W'(idx) << REG_LSB;
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // hold off until every expected result is back and the block is quiet
  task automatic drain;
    @(posedge clk);
    while (pending != 0 || out_valid) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  // send one item; hold valid until accepted, keep valid high across
  // back-to-back items
  task automatic send(logic cmd, logic signed [COORD_W-1:0] cx, cy, cz, px, py, pz,
                      logic ac, logic keep);
    in_valid <= 1;
    command <= cmd;
    cur_x <= cx; cur_y <= cy; cur_z <= cz;
    prev_x <= px; prev_y <= py; prev_z <= pz;
    already_collided <= ac;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!keep) in_valid <= 0;
  endtask

  function automatic logic signed [COORD_W-1:0] rnd_coord(int span);
    if ($urandom_range(0, 9) == 0) return COORD_W'($urandom);
    return COORD_W'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // mostly segments that straddle the plane near the square, some noise
  task automatic send_random(logic keep);
    int span;
    logic signed [COORD_W-1:0] cx, cy, cz, px, py, pz;
    span = ($urandom_range(0, 7) == 0) ? 300000 : 700;
    cx = rnd_coord(span); cz = rnd_coord(span);
    px = rnd_coord(span); pz = rnd_coord(span);
    cy = rnd_coord(span); py = rnd_coord(span);
    if ($urandom_range(0, 3) != 0) begin
      cy = COORD_W'($urandom_range(0, span));
      py = -COORD_W'($urandom_range(0, span));
    end
    send($urandom_range(0, 5) != 0, cx, cy, cz, px, py, pz, $urandom_range(0, 1), keep);
  endtask

  task automatic random_phase(int n);
    int left, burst;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && left > 0; k++) begin
        left--;
        send_random(k + 1 < burst && left > 0);
      end
      in_valid <= 0;
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    drain();
  endtask

  function automatic logic [47:0] pack_axis(int a, int b, int c);
    return {16'(c), 16'(b), 16'(a)};
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    repeat (3) @(posedge clk);

    // directed: resolved collider with bounce and friction
    write_reg(REG_RESPONSE, {4'b1001, 16'sd8192, 16'sd12000});
    write_reg(REG_HIT_COLOR, 64'hFF00_80C0);
    send(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
    send(CMD_PARTICLE, 10, 100, 20, 30, -100, -10, 0, 1);   // hit, resolved
    send(CMD_PARTICLE, 10, 100, 20, 30, -100, -10, 1, 1);   // hit, already collided
    send(CMD_PARTICLE, 900, 100, 0, 900, -100, 0, 0, 1);    // crosses outside
    send(CMD_PARTICLE, 0, 0, 0, 0, 0, 0, 0, 1);             // both on plane
    send(CMD_PARTICLE, 5, 50, 5, 5, 40, 5, 0, 1);           // no crossing
    send(CMD_PARTICLE, 255, 10, 0, 255, -10, 0, 0, 1);      // edge, inside
    send(CMD_PARTICLE, 256, 10, 0, 256, -10, 0, 0, 1);      // edge, outside
    send(CMD_PARTICLE, 524287, 524287, 524287, -524288, -524288, -524288, 0, 1);
    send(CMD_PARTICLE, -524288, 524287, -524288, 524287, -524288, 524287, 0, 1);
    send(CMD_PARTICLE, 0, -524288, 0, 0, 524287, 0, 1, 0);  // saturates
    send(CMD_TICK, -1, -1, -1, -1, -1, -1, 1, 0);
    drain();
    // killer, then no resolve, then disabled
    write_reg(REG_RESPONSE, {4'b0011, 32'h0});
    send(CMD_PARTICLE, 10, 100, 20, 30, -100, -10, 0, 0);
    drain();
    write_reg(REG_RESPONSE, {4'b1101, 32'hFFFF_8000});
    send(CMD_PARTICLE, 10, 100, 20, 30, -100, -10, 0, 0);
    drain();
    write_reg(REG_RESPONSE, {4'b1110, 32'h4000_4000});
    send(CMD_PARTICLE, 10, 100, 20, 30, -100, -10, 0, 0);
    drain();

    // random phases over several collider settings
    for (phase_count = 0; phase_count < 7; phase_count++) begin
      case (phase_count)
        0: begin
          write_reg(REG_RESPONSE, {4'b0001, 16'sd16384, 16'sd0});
        end
        1: begin
          write_reg(REG_ORIGIN, {20'(-300), 20'(100), 20'(50)});
          write_reg(REG_HALF_W, 19'h7FFFF);
          write_reg(REG_HALF_H, 19'd1);
          write_reg(REG_RESPONSE, {4'b1001, 16'h8000, 16'h7FFF});
        end
        2: begin
          // tilted plane: 45 degrees about z
          write_reg(REG_ORIGIN, '0);
          write_reg(REG_AXIS_X, pack_axis(11585, -11585, 0));
          write_reg(REG_AXIS_Y, pack_axis(11585, 11585, 0));
          write_reg(REG_HALF_W, 19'd600);
          write_reg(REG_HALF_H, 19'd600);
          write_reg(REG_RESPONSE, {4'b0101, 16'sd9000, 16'sd3000});
        end
        3: begin
          // non-unit axes and extreme components
          write_reg(REG_AXIS_X, pack_axis(-32768, 32767, 1));
          write_reg(REG_AXIS_Y, pack_axis(0, -32768, 0));
          write_reg(REG_AXIS_Z, pack_axis(32767, 0, -32768));
          write_reg(REG_HALF_W, 19'h7FFFF);
          write_reg(REG_HALF_H, 19'h7FFFF);
          write_reg(REG_RESPONSE, {4'b1001, 16'hFFFF, 16'h0001});
        end
        4: begin
          write_reg(REG_ORIGIN, {20'h7FFFF, 20'h80000, 20'h7FFFF});
          write_reg(REG_AXIS_X, AXIS_X_RST);
          write_reg(REG_AXIS_Y, AXIS_Y_RST);
          write_reg(REG_AXIS_Z, AXIS_Z_RST);
          write_reg(REG_RESPONSE, {4'b1111, 32'hFFFF_FFFF});
        end
        5: begin
          write_reg(REG_ORIGIN, 64'hFFFF_FFFF_FFFF_FFFF);
          write_reg(REG_HALF_W, 19'd400);
          write_reg(REG_HALF_H, 19'd300);
          write_reg(REG_RESPONSE, {4'b1001, 32'h0000_0000});
          write_reg(REG_HIT_COLOR, 64'hFFFF_FFFF);
        end
        default: begin
          write_reg(REG_ORIGIN, '0);
          write_reg(REG_RESPONSE, {4'b1001, 16'($urandom_range(0, 65535)), 16'($urandom)});
        end
      endcase
      random_phase(N_RANDOM / 7);
    end

    drain();
    $display("covered %0d results, %0d hits, over 7 random register settings",
             result_seen, hit_seen);
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
